// ===== src/mpf_pkg.sv =====
// Shared types and constants for the monochrome page frame buffer.
`default_nettype none

package mpf_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;

    // Address and count widths cover the largest parameter setting (256 x 128).
    localparam int CMD_ADDR_W = 12;
    localparam int USED_W     = 13;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] COLOR_BLACK   = 2'd0;
    localparam logic [1:0] COLOR_WHITE   = 2'd1;
    localparam logic [1:0] COLOR_INVERSE = 2'd2;

    localparam logic [1:0] PANEL_64X32  = 2'd0;
    localparam logic [1:0] PANEL_128X64 = 2'd1;

    localparam logic [0:0] REG_PANEL_SIZE = 1'b0;
    localparam logic [1:0] PANEL_SIZE_RESET = 2'd2;

    localparam logic [7:0] FILL_WHITE = 8'hFF;
    localparam logic [7:0] FILL_BLACK = 8'h00;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_DRAW,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    // addr: byte address for draw/read, last byte index for clear
    typedef struct packed {
        cmd_kind_t             kind;
        logic [CMD_ADDR_W-1:0] addr;
        logic [7:0]            mask;
        logic [1:0]            color;
        logic                  oor;
    } cmd_t;

endpackage

`default_nettype wire

// ===== src/mpf_if.sv =====
// Item channel interfaces for requests and responses.
`default_nettype none

interface mpf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic [1:0] color;
    logic [9:0] byte_index;

    modport source (output valid, opcode, pixel_x, pixel_y, color, byte_index, input ready);
    modport sink (input valid, opcode, pixel_x, pixel_y, color, byte_index, output ready);
endinterface

interface mpf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       out_of_range;

    modport source (output valid, read_data, out_of_range, input ready);
    modport sink (input valid, read_data, out_of_range, output ready);
endinterface

`default_nettype wire

// ===== src/mpf_front.sv =====
// Front end: accepts request items and decodes them into store commands.
`default_nettype none

module mpf_front #(
    parameter int MAX_WIDTH  = mpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mpf_pkg::DEF_MAX_HEIGHT
) (
    mpf_req_if.sink       req,
    input  wire [1:0]     panel_size,
    input  wire           q_full,
    input  wire           init_busy,
    output logic          push,
    output mpf_pkg::cmd_t cmd
);

    localparam int StoreBytes = MAX_WIDTH * ((MAX_HEIGHT + 7) / 8);

    logic [8:0]                       width_base;
    logic [8:0]                       pw;
    logic [7:0]                       height_base;
    logic [7:0]                       ph;
    logic [3:0]                       pages;
    logic [mpf_pkg::USED_W-1:0]       used_raw;
    logic [mpf_pkg::USED_W-1:0]       used;
    logic [mpf_pkg::CMD_ADDR_W-1:0]   draw_addr;
    logic                             draw_ok;
    logic                             read_ok;

    assign req.ready = !q_full && !init_busy;
    assign push      = req.valid && req.ready;

    always_comb
    begin
        width_base  = (panel_size == mpf_pkg::PANEL_64X32) ? 9'd64 : 9'd128;
        pw          = (width_base > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_base;
        height_base = (panel_size == mpf_pkg::PANEL_128X64) ? 8'd64 : 8'd32;
        ph          = (height_base > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : height_base;
        pages       = 4'(({1'b0, ph} + 9'd7) >> 3);
        used_raw    = mpf_pkg::USED_W'(pw * pages);
        used        = (used_raw > mpf_pkg::USED_W'(StoreBytes))
                    ? mpf_pkg::USED_W'(StoreBytes) : used_raw;

        draw_addr = mpf_pkg::CMD_ADDR_W'(req.pixel_y[5:3] * pw)
                  + mpf_pkg::CMD_ADDR_W'(req.pixel_x);
        draw_ok   = ({2'b0, req.pixel_x} < pw) && ({2'b0, req.pixel_y} < ph)
                 && ({1'b0, draw_addr} < mpf_pkg::USED_W'(StoreBytes));
        read_ok   = ({3'b0, req.byte_index} < used);

        cmd.kind  = mpf_pkg::CMD_NOP;
        cmd.addr  = draw_addr;
        cmd.mask  = 8'b1 << req.pixel_y[2:0];
        cmd.color = req.color;
        cmd.oor   = 1'b0;

        unique case (req.opcode)
            mpf_pkg::OP_DRAW:
            begin
                if (!draw_ok)
                    cmd.oor = 1'b1;
                else if (req.color == mpf_pkg::COLOR_BLACK
                      || req.color == mpf_pkg::COLOR_WHITE
                      || req.color == mpf_pkg::COLOR_INVERSE)
                    cmd.kind = mpf_pkg::CMD_DRAW;
            end
            mpf_pkg::OP_CLEAR:
            begin
                cmd.addr = mpf_pkg::CMD_ADDR_W'(used - 1'b1);
                if (req.color == mpf_pkg::COLOR_WHITE || req.color == mpf_pkg::COLOR_BLACK)
                    cmd.kind = mpf_pkg::CMD_CLEAR;
            end
            mpf_pkg::OP_READ:
            begin
                cmd.addr = mpf_pkg::CMD_ADDR_W'(req.byte_index);
                if (read_ok)
                    cmd.kind = mpf_pkg::CMD_READ;
                else
                    cmd.oor = 1'b1;
            end
            default:
            begin
                cmd.kind = mpf_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/mpf_queue.sv =====
// Two-entry command queue between the front end and the store engine.
`default_nettype none

module mpf_queue (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           push,
    input  mpf_pkg::cmd_t push_cmd,
    output logic          full,
    input  wire           pop,
    output logic          not_empty,
    output mpf_pkg::cmd_t pop_cmd
);

    mpf_pkg::cmd_t entries_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ===== src/mpf_back.sv =====
// Store engine: owns the frame memory and executes decoded commands.
`default_nettype none

module mpf_back #(
    parameter int MAX_WIDTH  = mpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mpf_pkg::DEF_MAX_HEIGHT
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           q_valid,
    input  mpf_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          init_busy,
    mpf_rsp_if.source     rsp
);

    localparam int StoreBytes = MAX_WIDTH * ((MAX_HEIGHT + 7) / 8);
    localparam int AW         = $clog2(StoreBytes);
    localparam logic [AW-1:0] LastIdx = AW'(StoreBytes - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_CLEAR
    } state_t;

    logic [7:0]    mem [StoreBytes];
    logic [7:0]    rdata_reg;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    mpf_pkg::cmd_t cur_reg, cur_next;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_oor_reg, out_oor_next;

    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    draw_byte;

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_data_reg;
    assign rsp.out_of_range = out_oor_reg;
    assign init_busy        = (state_reg == ST_INIT);
    assign out_free         = !out_valid_reg || rsp.ready;
    assign mem_raddr        = q_cmd.addr[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        case (cur_reg.color)
            mpf_pkg::COLOR_BLACK:   draw_byte = rdata_reg & ~cur_reg.mask;
            mpf_pkg::COLOR_WHITE:   draw_byte = rdata_reg | cur_reg.mask;
            mpf_pkg::COLOR_INVERSE: draw_byte = rdata_reg ^ cur_reg.mask;
            default:                draw_byte = rdata_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        out_oor_next   = out_oor_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = mpf_pkg::FILL_BLACK;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                if (cnt_reg == LastIdx)
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop      = 1'b1;
                    cur_next = q_cmd;
                    cnt_next = '0;
                    unique case (q_cmd.kind)
                        mpf_pkg::CMD_READ:
                        begin
                            state_next = ST_READ;
                        end
                        mpf_pkg::CMD_DRAW,
                        mpf_pkg::CMD_CLEAR,
                        mpf_pkg::CMD_NOP:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = 8'h00;
                            out_oor_next   = q_cmd.oor;
                            if (q_cmd.kind == mpf_pkg::CMD_DRAW)
                                state_next = ST_DRAW;
                            else if (q_cmd.kind == mpf_pkg::CMD_CLEAR)
                                state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cur_reg.addr[AW-1:0];
                mem_wdata  = draw_byte;
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rdata_reg;
                out_oor_next   = 1'b0;
                state_next     = ST_IDLE;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (cur_reg.color == mpf_pkg::COLOR_WHITE)
                          ? mpf_pkg::FILL_WHITE : mpf_pkg::FILL_BLACK;
                if (cnt_reg == cur_reg.addr[AW-1:0])
                    state_next = ST_IDLE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= 8'h00;
            out_oor_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_oor_reg   <= out_oor_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mono_page_framebuffer.sv =====
// Top level of the monochrome page frame buffer.
//
// req carries one item per valid/ready handshake: opcode draw, clear or read,
// with pixel_x, pixel_y, color and byte_index. rsp returns exactly one item
// per request, in order: read_data and out_of_range. panel_size is written
// via APB at byte address 0; the user must do so only while idle, unenforced.
//
// Steps in the store engine after the two-entry command queue:
//   draw  : synchronous read, then write of the modified byte
//   read  : synchronous read, then ST_READ registers the byte as the response
//   clear : one byte written per cycle over the used area
//   other : the response is registered and the engine stays idle
// The frame memory's synchronous read sets this order of steps.
// With an idle engine an item passes the command queue, then the response
// register raises rsp.valid; a read passes through ST_READ before that.
//
// After reset the engine zeroes the whole store, MAX_WIDTH * ceil(MAX_HEIGHT/8)
// bytes (1024 by default); req.ready stays low meanwhile.
// A stalled rsp holds its item; up to two more requests queue behind it.
`default_nettype none

module mono_page_framebuffer #(
    parameter int MAX_WIDTH  = mpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mpf_pkg::DEF_MAX_HEIGHT
) (
    input  wire         clk,
    input  wire         rst_n,
    mpf_req_if.sink     req,
    mpf_rsp_if.source   rsp,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]    panel_size_reg;
    logic          cfg_wr;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    logic          init_busy;
    mpf_pkg::cmd_t push_cmd;
    mpf_pkg::cmd_t q_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2:2] == mpf_pkg::REG_PANEL_SIZE);
    assign prdata = (paddr[2:2] == mpf_pkg::REG_PANEL_SIZE) ? {30'b0, panel_size_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            panel_size_reg <= mpf_pkg::PANEL_SIZE_RESET;
        else if (cfg_wr)
            panel_size_reg <= pwdata[1:0];
    end

    mpf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .req        (req),
        .panel_size (panel_size_reg),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    mpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_cmd   (q_cmd)
    );

    mpf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .init_busy (init_busy),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== src/mpf_checker.sv =====
// Port-level assertions for the frame buffer, bound to the top level.
`default_nettype none

module mpf_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       req_valid,
    input wire       req_ready,
    input wire       rsp_valid,
    input wire       rsp_ready,
    input wire [7:0] rsp_read_data,
    input wire       rsp_out_of_range
);

    logic [2:0] pending_reg;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else if (req_acc && !rsp_acc)
            pending_reg <= pending_reg + 3'd1;
        else if (rsp_acc && !req_acc)
            pending_reg <= pending_reg - 3'd1;
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_out_of_range |-> rsp_read_data == 8'h00)
        else $error("out-of-range item carries data");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("response without a pending request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("too many items in flight");

endmodule

bind mono_page_framebuffer mpf_checker u_mpf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_read_data    (rsp.read_data),
    .rsp_out_of_range (rsp.out_of_range)
);

`default_nettype wire

// ===== tb/mono_page_framebuffer_test.sv =====
// Self-checking testbench for the monochrome page frame buffer: draw, clear and read items.
`timescale 1ns / 100ps

module mono_page_framebuffer_test;

    localparam int STORE_BYTES = mpf_pkg::DEF_MAX_WIDTH * ((mpf_pkg::DEF_MAX_HEIGHT + 7) / 8);
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int CLEAR_SETTLE = STORE_BYTES + 80;
    localparam int PHASE_ITEMS = 500;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER = 200;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] COLOR_UNUSED = 2'd3;
    localparam logic [1:0] PANEL_128X32 = 2'd2;
    localparam logic [1:0] PANEL_ALIAS  = 2'd3;

    typedef struct {
        logic [7:0] read_data;
        logic       out_of_range;
    } pixel_rsp_t;

    class frame_scoreboard;
        logic [7:0] pixels [STORE_BYTES];
        logic [1:0] panel_size;
        pixel_rsp_t awaited_rsp [$];
        int errors;

        function new();
            foreach (pixels[i])
                pixels[i] = mpf_pkg::FILL_BLACK;
            panel_size = mpf_pkg::PANEL_SIZE_RESET;
            errors = 0;
        endfunction

        function void set_panel_size(logic [1:0] size);
            panel_size = size;
        endfunction

        function int width();
            return (panel_size == mpf_pkg::PANEL_64X32) ? 64 : 128;
        endfunction

        function int height();
            return (panel_size == mpf_pkg::PANEL_128X64) ? 64 : 32;
        endfunction

        function int used_bytes();
            return width() * ((height() + 7) / 8);
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction

        // Apply one accepted item to the store copy and queue its response.
        function void note_request(logic [1:0] opcode, logic [6:0] x, logic [5:0] y,
                                   logic [1:0] color, logic [9:0] index);
            pixel_rsp_t rsp;
            int addr;
            logic [7:0] mask;
            rsp.read_data = 8'h00;
            rsp.out_of_range = 1'b0;
            if (opcode == mpf_pkg::OP_DRAW)
            begin
                if (int'(x) >= width() || int'(y) >= height())
                    rsp.out_of_range = 1'b1;
                else
                begin
                    addr = (int'(y) / 8) * width() + int'(x);
                    mask = 8'(1 << (y % 8));
                    case (color)
                        mpf_pkg::COLOR_WHITE:   pixels[addr] = pixels[addr] | mask;
                        mpf_pkg::COLOR_BLACK:   pixels[addr] = pixels[addr] & ~mask;
                        mpf_pkg::COLOR_INVERSE: pixels[addr] = pixels[addr] ^ mask;
                        default:                ;
                    endcase
                end
            end
            else if (opcode == mpf_pkg::OP_CLEAR)
            begin
                if (color == mpf_pkg::COLOR_WHITE || color == mpf_pkg::COLOR_BLACK)
                    for (int i = 0; i < used_bytes(); i++)
                        pixels[i] = (color == mpf_pkg::COLOR_WHITE)
                                  ? mpf_pkg::FILL_WHITE : mpf_pkg::FILL_BLACK;
            end
            else if (opcode == mpf_pkg::OP_READ)
            begin
                if (int'(index) < used_bytes())
                    rsp.read_data = pixels[index];
                else
                    rsp.out_of_range = 1'b1;
            end
            awaited_rsp.push_back(rsp);
        endfunction

        function void check_response(logic [7:0] read_data, logic out_of_range);
            pixel_rsp_t want;
            if (awaited_rsp.size() == 0)
            begin
                $error("response with none pending: read_data %0h out_of_range %0b",
                       read_data, out_of_range);
                errors++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (read_data !== want.read_data)
            begin
                $error("read_data: expected %0h, got %0h", want.read_data, read_data);
                errors++;
            end
            if (out_of_range !== want.out_of_range)
            begin
                $error("out_of_range: expected %0b, got %0b", want.out_of_range, out_of_range);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mpf_req_if req_ch();
    mpf_rsp_if rsp_ch();

    frame_scoreboard frame_sb = new();
    int accepted_reqs = 0;
    int cycle_count = 0;

    mono_page_framebuffer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            frame_sb.check_response(rsp_ch.read_data, rsp_ch.out_of_range);

    // Response side: random stalls, free-running stretches, one long hold-off.
    initial
    begin
        int run_len;
        int stall_len;
        bit long_hold_done;
        long_hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && accepted_reqs > LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(3) == 0)
                run_len = $urandom_range(150, 50);
            else
                run_len = $urandom_range(8, 1);
            stall_len = $urandom_range(5, 1);
            rsp_ch.ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            rsp_ch.ready <= 1'b0;
            repeat (stall_len) @(posedge clk);
        end
    end

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_request(input logic [1:0] opcode, input logic [6:0] x,
                                input logic [5:0] y, input logic [1:0] color,
                                input logic [9:0] index);
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= opcode;
        req_ch.pixel_x    <= x;
        req_ch.pixel_y    <= y;
        req_ch.color      <= color;
        req_ch.byte_index <= index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        frame_sb.note_request(opcode, x, y, color, index);
        accepted_reqs++;
    endtask

    task automatic idle_request(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_panel_size(input logic [1:0] size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(mpf_pkg::REG_PANEL_SIZE) << 2;
        pwdata  <= 32'(size);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_sb.set_panel_size(size);
    endtask

    // Wait for every response, then let a full clear walk finish.
    task automatic drain_store;
        req_ch.valid <= 1'b0;
        while (frame_sb.pending() != 0)
            @(posedge clk);
        repeat (CLEAR_SETTLE) @(posedge clk);
    endtask

    task automatic random_request;
        logic [1:0] opcode;
        logic [6:0] x;
        logic [5:0] y;
        logic [9:0] index;
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            opcode = mpf_pkg::OP_DRAW;
        else if (pick < 90)
            opcode = mpf_pkg::OP_READ;
        else if (pick < 95)
            opcode = mpf_pkg::OP_CLEAR;
        else
            opcode = OP_UNUSED;
        x = ($urandom_range(99) < 85) ? 7'($urandom_range(frame_sb.width() - 1))
                                      : 7'($urandom_range(127));
        y = ($urandom_range(99) < 85) ? 6'($urandom_range(frame_sb.height() - 1))
                                      : 6'($urandom_range(63));
        index = ($urandom_range(99) < 85) ? 10'($urandom_range(frame_sb.used_bytes() - 1))
                                          : 10'($urandom_range(1023));
        send_request(opcode, x, y, 2'($urandom_range(3)), index);
    endtask

    task automatic random_phase(input int count);
        int burst_left;
        burst_left = $urandom_range(24, 1);
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                idle_request($urandom_range(10, 1));
                burst_left = ($urandom_range(9) == 0) ? 100 : $urandom_range(24, 1);
            end
            random_request();
            burst_left--;
        end
    endtask

    task automatic directed_requests;
        send_request(mpf_pkg::OP_DRAW, 7'd0, 6'd0, mpf_pkg::COLOR_WHITE, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd0);
        send_request(mpf_pkg::OP_DRAW, 7'd127, 6'd31, mpf_pkg::COLOR_WHITE, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd511);
        send_request(mpf_pkg::OP_DRAW, 7'd127, 6'd32, mpf_pkg::COLOR_WHITE, 10'd0);
        send_request(mpf_pkg::OP_DRAW, 7'd0, 6'd63, mpf_pkg::COLOR_WHITE, 10'd1023);
        send_request(mpf_pkg::OP_DRAW, 7'd127, 6'd0, mpf_pkg::COLOR_INVERSE, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd127);
        send_request(mpf_pkg::OP_DRAW, 7'd127, 6'd0, mpf_pkg::COLOR_INVERSE, 10'd0);
        send_request(mpf_pkg::OP_DRAW, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd0);
        send_request(mpf_pkg::OP_DRAW, 7'd5, 6'd5, COLOR_UNUSED, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd512);
        send_request(mpf_pkg::OP_READ, 7'd127, 6'd63, COLOR_UNUSED, 10'd1023);
        send_request(mpf_pkg::OP_CLEAR, 7'd0, 6'd0, mpf_pkg::COLOR_WHITE, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd511);
        send_request(mpf_pkg::OP_DRAW, 7'd64, 6'd9, mpf_pkg::COLOR_BLACK, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd192);
        send_request(mpf_pkg::OP_CLEAR, 7'd0, 6'd0, mpf_pkg::COLOR_INVERSE, 10'd0);
        send_request(mpf_pkg::OP_CLEAR, 7'd0, 6'd0, COLOR_UNUSED, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd0);
        send_request(OP_UNUSED, 7'd127, 6'd63, COLOR_UNUSED, 10'd1023);
        send_request(mpf_pkg::OP_CLEAR, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd0);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd192);
        send_request(mpf_pkg::OP_READ, 7'd0, 6'd0, mpf_pkg::COLOR_BLACK, 10'd511);
    endtask

    initial
    begin
        logic [1:0] sizes [4];
        sizes = '{mpf_pkg::PANEL_64X32, mpf_pkg::PANEL_128X64, PANEL_ALIAS, PANEL_128X32};
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= mpf_pkg::OP_DRAW;
        req_ch.pixel_x    <= '0;
        req_ch.pixel_y    <= '0;
        req_ch.color      <= mpf_pkg::COLOR_BLACK;
        req_ch.byte_index <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();
        drain_store();
        foreach (sizes[i])
        begin
            write_panel_size(sizes[i]);
            @(posedge clk);
            random_phase(PHASE_ITEMS);
            drain_store();
        end

        if (frame_sb.pending() != 0)
        begin
            $error("%0d responses never arrived", frame_sb.pending());
            frame_sb.errors++;
        end
        if (frame_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
